// ----- rtl/core/hpc_pkg.sv -----
package hpc_pkg;

    localparam int CELL_INDEX_W = 7;
    localparam int CELL_VALUE_W = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    // input commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INF_DIV    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ILL_DIV    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INC        = 2'd3;

    // neighborhood walk: center plus eight neighbors
    localparam int TAP_W    = 4;
    localparam int NUM_TAPS = 9;

    localparam int SUM_W = 12;  // nine bytes summed
    localparam int CNT_W = 4;   // neighbor count 0..8

    localparam int                    DIV_STEP_W      = 4;
    localparam logic [DIV_STEP_W-1:0] FULL_DIV_STEPS  = DIV_STEP_W'(SUM_W);
    localparam logic [DIV_STEP_W-1:0] SMALL_DIV_STEPS = DIV_STEP_W'(CNT_W);

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CLEAR,
        WR_LOAD,
        WR_STEP
    } t_wr_mode;

    typedef enum logic [1:0] {
        DIV_INF,
        DIV_ILL,
        DIV_AVG
    } t_div_op;

    typedef struct packed {
        logic             capture;
        t_wr_mode         wr;
        logic             rd_issue;
        logic [TAP_W-1:0] tap;
        logic             acc;
        logic             acc_center;
        logic             div_start;
        t_div_op          div_op;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic center_zero;
        logic center_mid;
        logic div_done;
    } t_dp_status;

endpackage

// ----- rtl/core/hodgepodge_cell_update.sv -----
// Channel   Handshake                  Payload
// input     start / busy               i_cmd, i_cell_index, i_cell_value
// result    o_result_strobe (1 cycle)  o_updated_index, o_updated_value, o_sweep_done
// config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A load beat is written in S_LOAD and its result is registered from that write. An
// update beat walks the nine cells through one bank read port, then runs the shared
// one-bit-per-cycle divider: one run for an average, two for a zero center (infected
// then ill counts), none otherwise; the divider runs set how long an update takes.
// After reset both banks are cleared, one address per cycle, with busy high. One beat
// in flight at a time; results cannot be stalled.
module hodgepodge_cell_update import hpc_pkg::*; #(
    parameter int ROW_WIDTH  = 16,
    parameter int BANK_CELLS = 128
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_cmd,
    input  logic [CELL_INDEX_W-1:0] i_cell_index,
    input  logic [CELL_VALUE_W-1:0] i_cell_value,
    output logic                    o_result_strobe,
    output logic [CELL_INDEX_W-1:0] o_updated_index,
    output logic [CELL_VALUE_W-1:0] o_updated_value,
    output logic                    o_sweep_done,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    t_dp_cmd    ctl;
    t_dp_status stat;

    assign o_cfg_ready = 1'b1;

    hpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_ctl   (ctl)
    );

    hpc_datapath #(
        .ROW_WIDTH  (ROW_WIDTH),
        .BANK_CELLS (BANK_CELLS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cell_index    (i_cell_index),
        .i_cell_value    (i_cell_value),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .o_result_strobe (o_result_strobe),
        .o_updated_index (o_updated_index),
        .o_updated_value (o_updated_value),
        .o_sweep_done    (o_sweep_done)
    );

endmodule

// ----- rtl/core/hpc_div.sv -----
module hpc_div import hpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SUM_W-1:0]      i_dividend,
    input  logic [7:0]            i_divisor,
    input  logic [DIV_STEP_W-1:0] i_steps,
    output logic                  o_done,
    output logic [SUM_W-1:0]      o_quotient
);

    // restoring divider, one quotient bit per cycle; a short run takes the
    // dividend left-aligned so only its top bits are consumed
    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic [SUM_W-1:0]      r_dvd;
    logic [SUM_W-1:0]      r_quo;
    logic [7:0]            r_rem;
    logic [7:0]            r_dsr;

    logic [8:0] trial;
    logic [8:0] trial_sub;
    logic       q_bit;

    always_comb begin
        trial     = {r_rem, r_dvd[SUM_W-1]};
        trial_sub = trial - {1'b0, r_dsr};
        q_bit     = (trial >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[SUM_W-2:0], 1'b0};
            r_rem <= q_bit ? trial_sub[7:0] : trial[7:0];
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/core/hpc_ctrl.sv -----
module hpc_ctrl import hpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_cmd,
    input  t_dp_status i_stat,
    output logic       o_busy,
    output t_dp_cmd    o_ctl
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_READ,
        S_DECIDE,
        S_DIV_INF,
        S_DIV_ILL,
        S_DIV_AVG,
        S_WRITE
    } t_state;

    t_state           r_state, n_state;
    logic             r_busy;
    logic [TAP_W-1:0] r_tap, n_tap;
    logic             accept;

    assign accept = i_start && !r_busy;

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        o_ctl   = '{capture: 1'b0, wr: WR_NONE, rd_issue: 1'b0, tap: r_tap,
                    acc: 1'b0, acc_center: 1'b0, div_start: 1'b0, div_op: DIV_INF};
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.wr = WR_CLEAR;
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    o_ctl.capture = 1'b1;
                    n_tap         = '0;
                    n_state       = (i_cmd == CMD_LOAD) ? S_LOAD : S_READ;
                end
            end
            S_LOAD: begin
                o_ctl.wr = WR_LOAD;
                n_state  = S_IDLE;
            end
            S_READ: begin
                // read data is registered and lands in the cycle after its address
                o_ctl.rd_issue   = (r_tap < TAP_W'(NUM_TAPS));
                o_ctl.acc        = (r_tap != '0);
                o_ctl.acc_center = (r_tap == TAP_W'(1));
                n_tap            = r_tap + 1'b1;
                if (r_tap == TAP_W'(NUM_TAPS)) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                priority if (i_stat.center_zero) begin
                    o_ctl.div_start = 1'b1;
                    o_ctl.div_op    = DIV_INF;
                    n_state         = S_DIV_INF;
                end else if (i_stat.center_mid) begin
                    o_ctl.div_start = 1'b1;
                    o_ctl.div_op    = DIV_AVG;
                    n_state         = S_DIV_AVG;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_DIV_INF: begin
                if (i_stat.div_done) begin
                    o_ctl.div_start = 1'b1;
                    o_ctl.div_op    = DIV_ILL;
                    n_state         = S_DIV_ILL;
                end
            end
            S_DIV_ILL: begin
                if (i_stat.div_done) n_state = S_WRITE;
            end
            S_DIV_AVG: begin
                if (i_stat.div_done) n_state = S_WRITE;
            end
            S_WRITE: begin
                o_ctl.wr = WR_STEP;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_tap   <= n_tap;
        end
    end

    assign o_busy = r_busy;

endmodule

// ----- rtl/core/hpc_datapath.sv -----
module hpc_datapath import hpc_pkg::*; #(
    parameter int ROW_WIDTH  = 16,
    parameter int BANK_CELLS = 128
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [CELL_INDEX_W-1:0] i_cell_index,
    input  logic [CELL_VALUE_W-1:0] i_cell_value,
    input  logic                    i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  t_dp_cmd                 i_ctl,
    output t_dp_status              o_stat,
    output logic                    o_result_strobe,
    output logic [CELL_INDEX_W-1:0] o_updated_index,
    output logic [CELL_VALUE_W-1:0] o_updated_value,
    output logic                    o_sweep_done
);

    localparam int AW = $clog2(BANK_CELLS);
    localparam logic [AW:0] BANK_END = (AW + 1)'(BANK_CELLS);

    // neighbor offsets folded into 0..BANK_CELLS-1
    localparam int RW0    = ROW_WIDTH % BANK_CELLS;
    localparam int RW1    = (ROW_WIDTH + 1) % BANK_CELLS;
    localparam int RWM    = (ROW_WIDTH - 1) % BANK_CELLS;
    localparam int OFF_W  = BANK_CELLS - 1;
    localparam int OFF_E  = 1;
    localparam int OFF_N  = (BANK_CELLS - RW0) % BANK_CELLS;
    localparam int OFF_S  = RW0;
    localparam int OFF_NW = (BANK_CELLS - RW1) % BANK_CELLS;
    localparam int OFF_NE = (BANK_CELLS - RWM) % BANK_CELLS;
    localparam int OFF_SW = RWM;
    localparam int OFF_SE = RW1;

    localparam int          LAST_I   = BANK_CELLS - ROW_WIDTH - 2;
    localparam bit          HAS_LAST = (LAST_I >= 0);
    localparam logic [AW:0] LAST_V   = (AW + 1)'(LAST_I);
    localparam logic [AW-1:0] START_X = AW'(RW1);

    localparam int IW        = (AW + 1 > CELL_INDEX_W) ? AW + 1 : CELL_INDEX_W;
    localparam int IDX_FOLDS = ((1 << CELL_INDEX_W) - 1) / BANK_CELLS;

    // configuration
    logic [7:0] r_num_states, r_inf_div, r_ill_div, r_increment;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_states <= 8'd64;
            r_inf_div    <= 8'd2;
            r_ill_div    <= 8'd3;
            r_increment  <= 8'd5;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NUM_STATES: r_num_states <= i_cfg_data;
                CFG_INF_DIV:    r_inf_div    <= i_cfg_data;
                CFG_ILL_DIV:    r_ill_div    <= i_cfg_data;
                CFG_INC:        r_increment  <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    logic [7:0] ill, k1_eff, k2_eff;
    assign ill    = r_num_states - 8'd1;
    assign k1_eff = (r_inf_div == '0) ? 8'd1 : r_inf_div;
    assign k2_eff = (r_ill_div == '0) ? 8'd1 : r_ill_div;

    // cell banks
    logic [CELL_VALUE_W-1:0] r_bank_a [BANK_CELLS];
    logic [CELL_VALUE_W-1:0] r_bank_b [BANK_CELLS];
    logic [CELL_VALUE_W-1:0] r_rd_a, r_rd_b;

    logic [AW-1:0] r_cursor;
    logic          r_bank_sel;
    logic [AW-1:0] r_clr_addr;

    // load beat capture
    logic [IW-1:0]           ld_fold;
    logic [AW-1:0]           r_ld_idx;
    logic [CELL_VALUE_W-1:0] r_ld_val;

    always_comb begin
        ld_fold = IW'(i_cell_index);
        for (int f = 0; f < IDX_FOLDS; f++) begin
            if (ld_fold >= IW'(BANK_CELLS)) ld_fold = ld_fold - IW'(BANK_CELLS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_ld_idx <= ld_fold[AW-1:0];
            r_ld_val <= i_cell_value;
        end
    end

    // read address: cursor plus folded offset, one wrap
    logic [AW-1:0] tap_off;
    logic [AW:0]   rd_sum, rd_wrap;
    logic [AW-1:0] rd_addr;

    always_comb begin
        unique case (i_ctl.tap)
            TAP_W'(0): tap_off = '0;
            TAP_W'(1): tap_off = AW'(OFF_W);
            TAP_W'(2): tap_off = AW'(OFF_E);
            TAP_W'(3): tap_off = AW'(OFF_N);
            TAP_W'(4): tap_off = AW'(OFF_S);
            TAP_W'(5): tap_off = AW'(OFF_NW);
            TAP_W'(6): tap_off = AW'(OFF_NE);
            TAP_W'(7): tap_off = AW'(OFF_SW);
            TAP_W'(8): tap_off = AW'(OFF_SE);
            default:   tap_off = '0;
        endcase
        rd_sum  = {1'b0, r_cursor} + {1'b0, tap_off};
        rd_wrap = rd_sum - BANK_END;
        rd_addr = (rd_sum >= BANK_END) ? rd_wrap[AW-1:0] : rd_sum[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_issue) begin
            r_rd_a <= r_bank_a[rd_addr];
            r_rd_b <= r_bank_b[rd_addr];
        end
    end

    logic [CELL_VALUE_W-1:0] rd_cell;
    assign rd_cell = r_bank_sel ? r_rd_b : r_rd_a;

    // neighborhood accumulation
    logic [SUM_W-1:0]        r_sum;
    logic [CNT_W-1:0]        r_ninf, r_nill;
    logic [CELL_VALUE_W-1:0] r_c;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_sum  <= '0;
            r_ninf <= '0;
            r_nill <= '0;
        end else if (i_ctl.acc) begin
            r_sum <= r_sum + SUM_W'(rd_cell);
            priority if (i_ctl.acc_center) begin
                r_c <= rd_cell;
            end else if (rd_cell == ill) begin
                r_nill <= r_nill + 1'b1;
            end else if (rd_cell != '0) begin
                r_ninf <= r_ninf + 1'b1;
            end
        end
    end

    // shared divider
    logic [SUM_W-1:0]      div_dvd;
    logic [7:0]            div_dsr;
    logic [DIV_STEP_W-1:0] div_steps;
    logic                  div_done;
    logic [SUM_W-1:0]      div_quo;
    t_div_op               r_cur_op;
    logic [CNT_W-1:0]      r_q_inf, r_q_ill;
    logic [SUM_W-1:0]      r_q_avg;

    always_comb begin
        unique case (i_ctl.div_op)
            DIV_INF: begin
                div_dvd   = {r_ninf, {(SUM_W - CNT_W){1'b0}}};
                div_dsr   = k1_eff;
                div_steps = SMALL_DIV_STEPS;
            end
            DIV_ILL: begin
                div_dvd   = {r_nill, {(SUM_W - CNT_W){1'b0}}};
                div_dsr   = k2_eff;
                div_steps = SMALL_DIV_STEPS;
            end
            DIV_AVG: begin
                div_dvd   = r_sum;
                div_dsr   = 8'(r_ninf) + 8'd1;
                div_steps = FULL_DIV_STEPS;
            end
            default: begin
                div_dvd   = r_sum;
                div_dsr   = 8'd1;
                div_steps = FULL_DIV_STEPS;
            end
        endcase
    end

    hpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .i_steps    (div_steps),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.div_start) r_cur_op <= i_ctl.div_op;
        if (div_done) begin
            unique case (r_cur_op)
                DIV_INF: r_q_inf <= div_quo[CNT_W-1:0];
                DIV_ILL: r_q_ill <= div_quo[CNT_W-1:0];
                DIV_AVG: r_q_avg <= div_quo;
                default: ;
            endcase
        end
    end

    // new cell value
    logic                    center_zero, center_mid;
    logic [CNT_W:0]          small_sum;
    logic [CELL_VALUE_W-1:0] avg_inc, raw_nv, nv;

    always_comb begin
        center_zero = (r_c == '0);
        center_mid  = !center_zero && (r_c < ill);
        small_sum   = {1'b0, r_q_inf} + {1'b0, r_q_ill};
        avg_inc     = r_q_avg[CELL_VALUE_W-1:0] + r_increment;
        priority if (center_zero) raw_nv = CELL_VALUE_W'(small_sum);
        else if (center_mid)      raw_nv = avg_inc;
        else                      raw_nv = '0;
        nv = (raw_nv > ill) ? ill : raw_nv;
    end

    // cursor advance
    logic [AW:0]   cur_inc;
    logic          sweep_end;
    logic [AW-1:0] cur_next;

    always_comb begin
        cur_inc   = {1'b0, r_cursor} + 1'b1;
        sweep_end = HAS_LAST && (cur_inc > LAST_V);
        priority if (sweep_end)        cur_next = START_X;
        else if (cur_inc == BANK_END)  cur_next = '0;
        else                           cur_next = cur_inc[AW-1:0];
    end

    // bank write port
    logic                    we_a, we_b;
    logic [AW-1:0]           wr_addr;
    logic [CELL_VALUE_W-1:0] wr_data;

    always_comb begin
        unique case (i_ctl.wr)
            WR_NONE: begin
                we_a = 1'b0; we_b = 1'b0; wr_addr = r_cursor; wr_data = nv;
            end
            WR_CLEAR: begin
                we_a = 1'b1; we_b = 1'b1; wr_addr = r_clr_addr; wr_data = '0;
            end
            WR_LOAD: begin
                we_a = 1'b1; we_b = 1'b1; wr_addr = r_ld_idx; wr_data = r_ld_val;
            end
            WR_STEP: begin
                we_a = r_bank_sel; we_b = !r_bank_sel; wr_addr = r_cursor; wr_data = nv;
            end
            default: begin
                we_a = 1'b0; we_b = 1'b0; wr_addr = r_cursor; wr_data = nv;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_a) r_bank_a[wr_addr] <= wr_data;
        if (we_b) r_bank_b[wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor        <= START_X;
            r_bank_sel      <= 1'b0;
            r_clr_addr      <= '0;
            o_result_strobe <= 1'b0;
        end else begin
            o_result_strobe <= (i_ctl.wr == WR_LOAD) || (i_ctl.wr == WR_STEP);
            if (i_ctl.wr == WR_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_ctl.wr == WR_STEP) begin
                r_cursor <= cur_next;
                if (sweep_end) r_bank_sel <= ~r_bank_sel;
            end
        end
    end

    logic [AW+CELL_INDEX_W-1:0] idx_ext;
    assign idx_ext = {{CELL_INDEX_W{1'b0}}, wr_addr};

    always_ff @(posedge i_clk) begin
        if ((i_ctl.wr == WR_LOAD) || (i_ctl.wr == WR_STEP)) begin
            o_updated_index <= idx_ext[CELL_INDEX_W-1:0];
            o_updated_value <= wr_data;
            o_sweep_done    <= (i_ctl.wr == WR_STEP) && sweep_end;
        end
    end

    assign o_stat = '{clear_last:  (r_clr_addr == AW'(BANK_CELLS - 1)),
                      center_zero: center_zero,
                      center_mid:  center_mid,
                      div_done:    div_done};

endmodule

// ----- rtl/core/hpc_checker.sv -----
module hpc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic i_busy,
    input logic i_result_strobe
);

    // an accepted beat holds the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !i_busy |=> i_busy)
        else $error("busy not raised after accepted beat");

    // one result per beat, never back to back
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_strobe |=> !i_result_strobe)
        else $error("result strobe held two cycles");

    // a result closes a busy period
    a_strobe_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_strobe |-> !i_busy && $past(i_busy))
        else $error("result strobe outside end of busy period");

endmodule

bind hodgepodge_cell_update hpc_checker u_hpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (start),
    .i_busy          (busy),
    .i_result_strobe (o_result_strobe)
);

// ----- dv/hodgepodge_cell_update_test.sv -----
module hodgepodge_cell_update_test;
    import hpc_pkg::*;

    localparam int ROW_W         = 16;
    localparam int CELLS         = 128;
    localparam int FIRST_CELL    = ROW_W + 1;
    localparam int LAST_CELL     = CELLS - ROW_W - 2;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;
    localparam int NEIGHBOR_OFFSETS [8] = '{
        -1, 1, -ROW_W, ROW_W, -ROW_W - 1, -ROW_W + 1, ROW_W - 1, ROW_W + 1
    };

    typedef struct packed {
        logic [CELL_INDEX_W-1:0] index;
        logic [CELL_VALUE_W-1:0] value;
        logic                    done;
    } cell_result_t;

    logic                    i_clk;
    logic                    i_rst_n      = 1'b0;
    logic                    start        = 1'b0;
    logic                    busy;
    logic                    i_cmd        = CMD_LOAD;
    logic [CELL_INDEX_W-1:0] i_cell_index = '0;
    logic [CELL_VALUE_W-1:0] i_cell_value = '0;
    logic                    o_result_strobe;
    logic [CELL_INDEX_W-1:0] o_updated_index;
    logic [CELL_VALUE_W-1:0] o_updated_value;
    logic                    o_sweep_done;
    logic                    i_cfg_valid  = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index  = CFG_NUM_STATES;
    logic [CFG_DATA_W-1:0]   i_cfg_data   = '0;

    // shadow of the automaton
    logic [7:0] grid [2][CELLS];
    int         cursor    = FIRST_CELL;
    logic       bank_sel  = 1'b0;
    logic [7:0] q_reg     = 8'd64;
    logic [7:0] k1_reg    = 8'd2;
    logic [7:0] k2_reg    = 8'd3;
    logic [7:0] g_reg     = 8'd5;

    cell_result_t pending_results [$];
    int           fail_count   = 0;
    bit           steady_sender = 1'b0;

    hodgepodge_cell_update #(
        .ROW_WIDTH  (ROW_W),
        .BANK_CELLS (CELLS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_cell_index    (i_cell_index),
        .i_cell_value    (i_cell_value),
        .o_result_strobe (o_result_strobe),
        .o_updated_index (o_updated_index),
        .o_updated_value (o_updated_value),
        .o_sweep_done    (o_sweep_done),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
    endfunction

    // Applies one accepted beat to the shadow grid and returns the cell it leaves behind.
    function automatic cell_result_t predict_cell(input logic cmd,
                                                  input logic [CELL_INDEX_W-1:0] idx,
                                                  input logic [CELL_VALUE_W-1:0] val);
        cell_result_t r;
        logic [7:0]   ill, c, v, nv;
        int           k1, k2, sum, ninf, nill, a;
        if (cmd == CMD_LOAD) begin
            grid[0][idx] = val;
            grid[1][idx] = val;
            r = '{idx, val, 1'b0};
            return r;
        end
        ill  = q_reg - 8'd1;
        k1   = (k1_reg == 0) ? 1 : int'(k1_reg);
        k2   = (k2_reg == 0) ? 1 : int'(k2_reg);
        c    = grid[bank_sel][cursor];
        sum  = c;
        ninf = 0;
        nill = 0;
        foreach (NEIGHBOR_OFFSETS[i]) begin
            a = (cursor + NEIGHBOR_OFFSETS[i] + CELLS) % CELLS;
            v = grid[bank_sel][a];
            sum += v;
            if (v == ill) nill++;
            else if (v != 0) ninf++;
        end
        if (c == 0) nv = 8'(ninf / k1 + nill / k2);
        else if (c < ill) nv = 8'(sum / (ninf + 1) + int'(g_reg));
        else nv = 8'd0;
        if (nv > ill) nv = ill;
        grid[bank_sel ^ 1'b1][cursor] = nv;
        r.index = CELL_INDEX_W'(cursor);
        r.value = nv;
        r.done  = 1'b0;
        cursor++;
        if (cursor > LAST_CELL) begin
            cursor   = FIRST_CELL;
            bank_sel = ~bank_sel;
            r.done   = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : result_check
        cell_result_t want;
        if (i_rst_n && o_result_strobe) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result: idx %0d val %0d done %0b",
                                       o_updated_index, o_updated_value, o_sweep_done));
            end else begin
                want = pending_results.pop_front();
                if (want.index !== o_updated_index || want.value !== o_updated_value ||
                    want.done !== o_sweep_done) begin
                    note_failure($sformatf(
                        "mismatch: expected idx %0d val %0d done %0b, got idx %0d val %0d done %0b",
                        want.index, want.value, want.done,
                        o_updated_index, o_updated_value, o_sweep_done));
                end
            end
        end
    end

    // start stays high from one beat to the next unless a gap is taken
    task automatic send_cell(input logic cmd, input logic [CELL_INDEX_W-1:0] idx,
                             input logic [CELL_VALUE_W-1:0] val);
        if (!steady_sender && $urandom_range(99) < 6) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_cmd        <= cmd;
        i_cell_index <= idx;
        i_cell_value <= val;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(predict_cell(cmd, idx, val));
    endtask

    task automatic drain_block();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_rules(input logic [7:0] q, input logic [7:0] k1,
                             input logic [7:0] k2, input logic [7:0] g);
        logic [CFG_DATA_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0]  regs [4];
        vals = '{q, k1, k2, g};
        regs = '{CFG_NUM_STATES, CFG_INF_DIV, CFG_ILL_DIV, CFG_INC};
        drain_block();
        foreach (regs[i]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        q_reg  = q;
        k1_reg = k1;
        k2_reg = k2;
        g_reg  = g;
    endtask

    // mostly zero, ill or healthy-infected values under the current q, some raw bytes
    function automatic logic [7:0] pick_value();
        logic [7:0] ill;
        int         r;
        ill = q_reg - 8'd1;
        r   = $urandom_range(9);
        if (r < 2) return 8'd0;
        if (r < 4) return ill;
        if (r < 8 && ill >= 2) return 8'($urandom_range(1, ill - 1));
        return 8'($urandom_range(255));
    endfunction

    task automatic test_load_extremes();
        send_cell(CMD_LOAD, 7'd0, 8'h00);
        send_cell(CMD_LOAD, 7'd127, 8'hFF);
        send_cell(CMD_LOAD, 7'd85, 8'hAA);
        send_cell(CMD_LOAD, 7'd42, 8'h55);
    endtask

    // hand-built neighborhoods around the first interior cells, reset rules (ill = 63)
    task automatic test_neighborhood();
        send_cell(CMD_LOAD, 7'd0, 8'd63);
        send_cell(CMD_LOAD, 7'd1, 8'd63);
        send_cell(CMD_LOAD, 7'd2, 8'd10);
        send_cell(CMD_LOAD, 7'd16, 8'd20);
        send_cell(CMD_LOAD, 7'd17, 8'd0);
        send_cell(CMD_LOAD, 7'd18, 8'd30);
        send_cell(CMD_LOAD, 7'd32, 8'd63);
        send_cell(CMD_LOAD, 7'd33, 8'd0);
        send_cell(CMD_LOAD, 7'd34, 8'd200);
        send_cell(CMD_STEP, 7'd0, 8'd0);      // healthy center
        send_cell(CMD_STEP, 7'd127, 8'hFF);   // infected center, average rule
        send_cell(CMD_LOAD, 7'd19, 8'd63);
        send_cell(CMD_STEP, 7'd0, 8'd0);      // ill center recovers
        send_cell(CMD_LOAD, 7'd20, 8'd255);
        send_cell(CMD_STEP, 7'd0, 8'd0);      // above ill, also reset to zero
    endtask

    task automatic test_random_phase(input logic [7:0] q, input logic [7:0] k1,
                                     input logic [7:0] k2, input logic [7:0] g,
                                     input int n_beats);
        set_rules(q, k1, k2, g);
        repeat (n_beats) begin
            if ($urandom_range(199) == 0) drain_block();
            if ($urandom_range(99) < 55)
                send_cell(CMD_STEP, 7'($urandom_range(127)), 8'($urandom_range(255)));
            else
                send_cell(CMD_LOAD, 7'($urandom_range(127)), pick_value());
        end
    endtask

    initial begin
        foreach (grid[b, i]) grid[b][i] = 8'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain_block();

        test_load_extremes();
        test_neighborhood();

        test_random_phase(8'd2, 8'd0, 8'd0, 8'd255, 150);
        test_random_phase(8'd255, 8'd255, 8'd255, 8'd0, 150);
        test_random_phase(8'd0, 8'd1, 8'd1, 8'd200, 150);   // ill wraps to 255
        test_random_phase(8'd1, 8'd3, 8'd2, 8'd7, 120);     // ill is zero
        steady_sender = 1'b1;
        test_random_phase(8'd64, 8'd2, 8'd3, 8'd5, 200);
        steady_sender = 1'b0;
        repeat (4) begin
            test_random_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 8'($urandom_range(255)), 130);
        end

        drain_block();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/hpc_pkg.sv
rtl/core/hpc_div.sv
rtl/core/hpc_ctrl.sv
rtl/core/hpc_datapath.sv
rtl/core/hodgepodge_cell_update.sv
rtl/core/hpc_checker.sv
dv/hodgepodge_cell_update_test.sv
